FILE: design/yuyv_to_rgb_pixel_pair_defines.svh
// Assertion helpers shared by the conversion block.
`ifndef YUYV_TO_RGB_PIXEL_PAIR_DEFINES_SVH
`define YUYV_TO_RGB_PIXEL_PAIR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define Y2RGB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define Y2RGB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/y2rgb_pkg.sv
package y2rgb_pkg;

    localparam int PIX_W    = 8;
    localparam int CHROMA_W = PIX_W + 1;
    localparam int TERM_W   = 10;
    localparam int SUM_W    = 11;
    localparam int COEF_W   = 18;
    localparam int PROD_W   = 27;
    localparam int FRAC_BITS = 15;

    localparam logic signed [CHROMA_W-1:0] CHROMA_OFFSET = 9'sd128;
    localparam logic signed [COEF_W-1:0]   COEF_R_V = 18'sd37221;
    localparam logic signed [COEF_W-1:0]   COEF_G_U = 18'sd12975;
    localparam logic signed [COEF_W-1:0]   COEF_G_V = 18'sd18949;
    localparam logic signed [COEF_W-1:0]   COEF_B_U = 18'sd66883;
    localparam logic [PIX_W-1:0]           PIX_MAX  = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] luma_first;
        logic [PIX_W-1:0] chroma_u;
        logic [PIX_W-1:0] luma_second;
        logic [PIX_W-1:0] chroma_v;
        logic             row_end_in;
    } pixel_pair_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_first;
        logic [PIX_W-1:0] green_first;
        logic [PIX_W-1:0] blue_first;
        logic [PIX_W-1:0] red_second;
        logic [PIX_W-1:0] green_second;
        logic [PIX_W-1:0] blue_second;
        logic             row_end_out;
    } pixel_pair_out_t;

    // Chroma contributions shared by both pixels of a pair (green is subtracted).
    typedef struct packed {
        logic signed [TERM_W-1:0] red;
        logic signed [TERM_W-1:0] green;
        logic signed [TERM_W-1:0] blue;
    } chroma_terms_t;

endpackage

FILE: design/y2rgb_chroma.sv
module y2rgb_chroma (
    input  logic [y2rgb_pkg::PIX_W-1:0] chroma_u,
    input  logic [y2rgb_pkg::PIX_W-1:0] chroma_v,
    output y2rgb_pkg::chroma_terms_t    terms
);

    logic signed [y2rgb_pkg::CHROMA_W-1:0] uc;
    logic signed [y2rgb_pkg::CHROMA_W-1:0] vc;
    logic signed [y2rgb_pkg::PROD_W-1:0]   prod_r;
    logic signed [y2rgb_pkg::PROD_W-1:0]   prod_g;
    logic signed [y2rgb_pkg::PROD_W-1:0]   prod_b;

    // Remove the chroma offset: range -128..127.
    assign uc = $signed({1'b0, chroma_u}) - y2rgb_pkg::CHROMA_OFFSET;
    assign vc = $signed({1'b0, chroma_v}) - y2rgb_pkg::CHROMA_OFFSET;

    assign prod_r = y2rgb_pkg::PROD_W'(vc) * y2rgb_pkg::PROD_W'(y2rgb_pkg::COEF_R_V);
    assign prod_g = y2rgb_pkg::PROD_W'(uc) * y2rgb_pkg::PROD_W'(y2rgb_pkg::COEF_G_U)
                  + y2rgb_pkg::PROD_W'(vc) * y2rgb_pkg::PROD_W'(y2rgb_pkg::COEF_G_V);
    assign prod_b = y2rgb_pkg::PROD_W'(uc) * y2rgb_pkg::PROD_W'(y2rgb_pkg::COEF_B_U);

    // Arithmetic shift floors toward minus infinity.
    assign terms.red   = y2rgb_pkg::TERM_W'(prod_r >>> y2rgb_pkg::FRAC_BITS);
    assign terms.green = y2rgb_pkg::TERM_W'(prod_g >>> y2rgb_pkg::FRAC_BITS);
    assign terms.blue  = y2rgb_pkg::TERM_W'(prod_b >>> y2rgb_pkg::FRAC_BITS);

endmodule

FILE: design/y2rgb_pixel.sv
module y2rgb_pixel (
    input  logic [y2rgb_pkg::PIX_W-1:0] luma,
    input  y2rgb_pkg::chroma_terms_t    terms,
    output logic [y2rgb_pkg::PIX_W-1:0] red,
    output logic [y2rgb_pkg::PIX_W-1:0] green,
    output logic [y2rgb_pkg::PIX_W-1:0] blue
);

    logic signed [y2rgb_pkg::SUM_W-1:0] luma_s;
    logic signed [y2rgb_pkg::SUM_W-1:0] sum_r;
    logic signed [y2rgb_pkg::SUM_W-1:0] sum_g;
    logic signed [y2rgb_pkg::SUM_W-1:0] sum_b;

    function automatic logic [y2rgb_pkg::PIX_W-1:0] clamp_pix(
        input logic signed [y2rgb_pkg::SUM_W-1:0] val
    );
        logic [y2rgb_pkg::PIX_W-1:0] res;
        if (val < 0) begin
            res = '0;
        end else if (val > $signed({3'b000, y2rgb_pkg::PIX_MAX})) begin
            res = y2rgb_pkg::PIX_MAX;
        end else begin
            res = val[y2rgb_pkg::PIX_W-1:0];
        end
        return res;
    endfunction

    assign luma_s = $signed({{(y2rgb_pkg::SUM_W - y2rgb_pkg::PIX_W){1'b0}}, luma});

    assign sum_r = luma_s + y2rgb_pkg::SUM_W'(terms.red);
    assign sum_g = luma_s - y2rgb_pkg::SUM_W'(terms.green);
    assign sum_b = luma_s + y2rgb_pkg::SUM_W'(terms.blue);

    assign red   = clamp_pix(sum_r);
    assign green = clamp_pix(sum_g);
    assign blue  = clamp_pix(sum_b);

endmodule

FILE: design/yuyv_to_rgb_pixel_pair.sv
// Path: an accepted word is held in the input register, converted, then held in the
//       result register, which drives m_valid and m_data.
// Throughput: one word per cycle while m_ready is high; the colour maths is
//             constant-coefficient and per word.
// Backpressure: s_ready drops only while both registers hold a word and m_ready is low.
// Reset: synchronous, active low; clears the two valid flags only, data registers keep.
`include "yuyv_to_rgb_pixel_pair_defines.svh"

module yuyv_to_rgb_pixel_pair (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  y2rgb_pkg::pixel_pair_in_t  s_data,

    output logic                       m_valid,
    input  logic                       m_ready,
    output y2rgb_pkg::pixel_pair_out_t m_data
);

    // Input stage: holds the accepted word.
    logic                       in_valid_reg;
    logic                       in_valid_next;
    y2rgb_pkg::pixel_pair_in_t  in_data_reg;

    // Result stage: holds the converted word until the sink takes it.
    logic                       out_valid_reg;
    logic                       out_valid_next;
    y2rgb_pkg::pixel_pair_out_t out_data_reg;
    y2rgb_pkg::pixel_pair_out_t out_data_next;

    logic                       out_free;
    logic                       in_adv;
    logic                       in_take;

    y2rgb_pkg::chroma_terms_t   terms;

    // Result register frees up when empty or when its word leaves this cycle.
    assign out_free = !out_valid_reg || m_ready;
    // Advance the input word into the result register.
    assign in_adv   = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign in_take  = s_valid && s_ready;

    assign in_valid_next  = in_take || (in_valid_reg && !out_free);
    assign out_valid_next = in_adv || (out_valid_reg && !m_ready);

    // Chroma terms are common to both pixels; compute them once.
    y2rgb_chroma u_chroma (
        .chroma_u (in_data_reg.chroma_u),
        .chroma_v (in_data_reg.chroma_v),
        .terms    (terms)
    );

    y2rgb_pixel u_pix_first (
        .luma  (in_data_reg.luma_first),
        .terms (terms),
        .red   (out_data_next.red_first),
        .green (out_data_next.green_first),
        .blue  (out_data_next.blue_first)
    );

    y2rgb_pixel u_pix_second (
        .luma  (in_data_reg.luma_second),
        .terms (terms),
        .red   (out_data_next.red_second),
        .green (out_data_next.green_second),
        .blue  (out_data_next.blue_second)
    );

    // Row end rides along unchanged.
    assign out_data_next.row_end_out = in_data_reg.row_end_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Data registers: load on transfer, hold otherwise.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_data_reg <= s_data;
        end
        if (in_adv) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `Y2RGB_ASSERT_NEXT(a_adv_fills_out, aclk, aresetn, in_adv, out_valid_reg,
        "advance lost a word")
    `Y2RGB_ASSERT_NEXT(a_take_fills_in, aclk, aresetn, in_take, in_valid_reg,
        "accepted word not held")
    `Y2RGB_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_ready,
        in_valid_reg && out_valid_reg && !m_ready, "input stalled without full pipe")
    `Y2RGB_ASSERT_NEXT(a_row_end_pass, aclk, aresetn, in_adv,
        out_data_reg.row_end_out == $past(in_data_reg.row_end_in), "row end flag corrupted")

endmodule
